/* hdl/tpc_pkg.sv */
// tpc_pkg: shared types, widths and helpers for the triangle plane clipper
// depends on nothing; every other hdl file uses it
package tpc_pkg;

  localparam int unsigned COORD_W       = 24;
  localparam int unsigned NORM_W        = 16;
  localparam int unsigned PROD_W        = COORD_W + 1 + NORM_W;
  localparam int unsigned D_W           = PROD_W + 2;
  localparam int unsigned DEN_W         = D_W + 1;
  localparam int unsigned DIV_W         = 32;
  localparam int unsigned SH_W          = $clog2(DEN_W - DIV_W + 1);
  localparam int unsigned T_BITS        = 28;
  localparam int unsigned T_W           = T_BITS + 1;
  localparam int unsigned DIV_STEPS     = T_W;
  localparam int unsigned DIV_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int unsigned LERP_LAT      = 2;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X  = 3'd0,
    CFG_NORMAL_Y  = 3'd1,
    CFG_NORMAL_Z  = 3'd2,
    CFG_POINT_X   = 3'd3,
    CFG_POINT_Y   = 3'd4,
    CFG_POINT_Z   = 3'd5,
    CFG_KEEP_FRONT = 3'd6
  } cfg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // element 0 is the first vertex
  typedef vec_t [2:0] tri_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } req_t;

  typedef struct packed {
    coord_t out_a_x;
    coord_t out_a_y;
    coord_t out_a_z;
    coord_t out_b_x;
    coord_t out_b_y;
    coord_t out_b_z;
    coord_t out_c_x;
    coord_t out_c_y;
    coord_t out_c_z;
    logic   last;
  } result_t;

  typedef struct packed {
    norm_t [2:0] normal;
    vec_t        point;
    logic        keep_front;
  } cfg_t;

  // kept-vertex count and the odd vertex out
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] sel;
  } cls_t;

  function automatic coord_t axis(vec_t v, logic [1:0] j);
    coord_t r;
    case (j)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  function automatic tri_t to_tri(req_t q);
    tri_t t;
    t[0] = '{x: q.a_x, y: q.a_y, z: q.a_z};
    t[1] = '{x: q.b_x, y: q.b_y, z: q.b_z};
    t[2] = '{x: q.c_x, y: q.c_y, z: q.c_z};
    return t;
  endfunction

  function automatic result_t to_result(tri_t t, logic last);
    result_t r;
    r.out_a_x = t[0].x;
    r.out_a_y = t[0].y;
    r.out_a_z = t[0].z;
    r.out_b_x = t[1].x;
    r.out_b_y = t[1].y;
    r.out_b_z = t[1].z;
    r.out_c_x = t[2].x;
    r.out_c_y = t[2].y;
    r.out_c_z = t[2].z;
    r.last    = last;
    return r;
  endfunction

endpackage

/* hdl/tpc_dist.sv */
// tpc_dist: two-stage signed plane distance of three vertices and side classification
// depends on tpc_pkg
module tpc_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tpc_pkg::tri_t                 vtx_i,
  input  tpc_pkg::cfg_t                 cfg_i,
  output logic                          valid_o,
  output logic signed [tpc_pkg::D_W-1:0] d_o [3],
  output tpc_pkg::cls_t                 cls_o
);
  import tpc_pkg::*;

  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [D_W-1:0]    d_d [3];
  logic signed [D_W-1:0]    d_q [3];
  cls_t                     cls_d, cls_q;
  logic                     va_q, vb_q;

  // stage a: per-axis products
  always_comb begin
    coord_t                  pc, qc;
    logic signed [COORD_W:0] diff;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pc   = axis(vtx_i[i], 2'(j));
        qc   = axis(cfg_i.point, 2'(j));
        diff = (COORD_W+1)'(pc) - (COORD_W+1)'(qc);
        prod_d[i][j] = diff * $signed(cfg_i.normal[j]);
      end
    end
  end

  // stage b: sums, kept flags, odd vertex
  always_comb begin
    logic [2:0] kept;
    logic       front;
    for (int i = 0; i < 3; i++) begin
      d_d[i] = D_W'(prod_q[i][0]) + D_W'(prod_q[i][1]) + D_W'(prod_q[i][2]);
      front  = ~d_d[i][D_W-1];
      kept[i] = (front == cfg_i.keep_front);
    end
    cls_d.cnt = {1'b0, kept[0]} + {1'b0, kept[1]} + {1'b0, kept[2]};
    cls_d.sel = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (kept[i] == (cls_d.cnt == 2'd1)) cls_d.sel = 2'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    d_q    <= d_d;
    cls_q  <= cls_d;
  end

  assign valid_o = vb_q;
  assign d_o     = d_q;
  assign cls_o   = cls_q;

endmodule

/* hdl/tpc_div.sv */
// tpc_div: pipelined restoring divider giving the edge parameter t in unsigned q1.28
// depends on tpc_pkg; numerator must not exceed the denominator
module tpc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [tpc_pkg::DIV_W-1:0]  an_i,
  input  logic [tpc_pkg::DIV_W-1:0]  ad_i,
  input  logic                       zero_i,
  output logic                       valid_o,
  output logic [tpc_pkg::T_W-1:0]    t_o
);
  import tpc_pkg::*;

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic [DIV_W:0]   r_in  [DIV_STAGES];
  logic [DIV_W-1:0] ad_in [DIV_STAGES];
  logic [T_W-1:0]   q_in  [DIV_STAGES];
  logic             z_in  [DIV_STAGES];
  logic             v_in  [DIV_STAGES];

  logic [DIV_W:0]   r_d   [DIV_STAGES];
  logic [T_W-1:0]   q_d   [DIV_STAGES];

  logic [DIV_W:0]   r_q   [LAST];
  logic [DIV_W-1:0] ad_q  [LAST];
  logic [T_W-1:0]   q_q   [DIV_STAGES];
  logic             z_q   [DIV_STAGES];
  logic             v_q   [DIV_STAGES];

  assign r_in[0]  = {1'b0, an_i};
  assign ad_in[0] = ad_i;
  assign q_in[0]  = '0;
  assign z_in[0]  = zero_i;
  assign v_in[0]  = valid_i;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign r_in[s]  = r_q[s-1];
      assign ad_in[s] = ad_q[s-1];
      assign q_in[s]  = q_q[s-1];
      assign z_in[s]  = z_q[s-1];
      assign v_in[s]  = v_q[s-1];
    end

    always_comb begin
      logic [DIV_W:0] r;
      logic [T_W-1:0] q;
      int             g;
      r = r_in[s];
      q = q_in[s];
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        g = s * DIV_PER_STAGE + j;
        if (g < DIV_STEPS) begin
          // first quotient bit weighs 2^28 and needs no shift
          if (g != 0) r = {r[DIV_W-1:0], 1'b0};
          if (r >= {1'b0, ad_in[s]}) begin
            r = r - {1'b0, ad_in[s]};
            q[T_W-1-g] = 1'b1;
          end
        end
      end
      r_d[s] = r;
      q_d[s] = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      q_q[s] <= q_d[s];
      z_q[s] <= z_in[s];
    end

    if (s < LAST) begin : g_carry
      always_ff @(posedge clk_i) begin
        r_q[s]  <= r_d[s];
        ad_q[s] <= ad_in[s];
      end
    end
  end

  assign valid_o = v_q[LAST];
  assign t_o     = z_q[LAST] ? '0 : q_q[LAST];

endmodule

/* hdl/tpc_lerp.sv */
// tpc_lerp: two-stage point on an edge, p1 + round((p2 - p1) * t), saturated
// depends on tpc_pkg
module tpc_lerp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  tpc_pkg::vec_t           p1_i,
  input  tpc_pkg::vec_t           p2_i,
  input  logic [tpc_pkg::T_W-1:0] t_i,
  output logic                    valid_o,
  output tpc_pkg::vec_t           r_o
);
  import tpc_pkg::*;

  localparam int unsigned PL_W = COORD_W + 1 + T_W + 1;
  localparam int unsigned OW   = PL_W - T_BITS + 1;
  localparam logic signed [PL_W-1:0] HALF = PL_W'(2 ** (T_BITS - 1));
  localparam logic signed [OW-1:0] MAXC = $signed(OW'({1'b0, {(COORD_W-1){1'b1}}}));
  localparam logic signed [OW-1:0] MINC = -MAXC - OW'(1);

  logic signed [PL_W-1:0] prod_d [3];
  logic signed [PL_W-1:0] prod_q [3];
  coord_t                 p1_q [3];
  coord_t                 res_d [3];
  coord_t                 res_q [3];
  logic                   va_q, vb_q;

  always_comb begin
    logic signed [COORD_W:0] dir;
    logic signed [T_W:0]     ts;
    ts = $signed({1'b0, t_i});
    for (int j = 0; j < 3; j++) begin
      dir = (COORD_W+1)'(axis(p2_i, 2'(j))) - (COORD_W+1)'(axis(p1_i, 2'(j)));
      prod_d[j] = dir * ts;
    end
  end

  // round half up, then clamp to the coordinate range
  always_comb begin
    logic signed [PL_W-1:0]        sum;
    logic signed [PL_W-T_BITS-1:0] off;
    logic signed [OW-1:0]          v;
    for (int j = 0; j < 3; j++) begin
      sum = prod_q[j] + HALF;
      off = $signed(sum[PL_W-1:T_BITS]);
      v   = OW'(p1_q[j]) + OW'(off);
      if (v > MAXC)      res_d[j] = MAXC[COORD_W-1:0];
      else if (v < MINC) res_d[j] = MINC[COORD_W-1:0];
      else               res_d[j] = v[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    p1_q[0]  <= p1_i.x;
    p1_q[1]  <= p1_i.y;
    p1_q[2]  <= p1_i.z;
    res_q    <= res_d;
  end

  assign valid_o = vb_q;
  assign r_o     = '{x: res_q[0], y: res_q[1], z: res_q[2]};

endmodule

/* hdl/triangle_plane_clipper.sv */
// triangle_plane_clipper: top level, clips one triangle against a configured plane
// depends on tpc_pkg, tpc_dist, tpc_div and tpc_lerp
//
// usage
//   request channel: a triangle on req_i is taken at a rising edge with start_i high
//   and busy_o low. busy_o is registered: each taken request raises it for a single cycle, so
//   requests are never taken back to back; the pair of result slots on the single
//   result port sets this limit.
//   result channel: res_valid_o marks each result triangle for exactly one cycle.
//   a request gives zero, one or two results; res_o.last flags the final one, and
//   two results come in back-to-back cycles. the receiver cannot stall, so nothing
//   is ever held back.
//   pipeline: 1 input register, 2 distance stages, operand and normalize stages,
//   8 divider stages of up to 4 quotient bits each, 2 interpolation stages and the
//   output register lie between a taken request and its first result; a new
//   triangle can enter while earlier ones are still in flight.
//   configuration: plain write port, register index on cfg_idx_i, no read-back.
//   write only while no request is in flight.
//   reset: all valid bits clear at once, the plane goes back to z-up through the
//   origin keeping the front side; no clearing pass is needed.
module triangle_plane_clipper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  tpc_pkg::req_t                    req_i,
  output logic                             busy_o,
  output logic                             res_valid_o,
  output tpc_pkg::result_t                 res_o,
  input  logic                             cfg_we_i,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tpc_pkg::*;

  localparam int unsigned LINE_LEN = DIV_STAGES + LERP_LAT;

  typedef struct packed {
    tri_t vtx;
    cls_t cls;
  } carry_t;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal[0] <= '0;
      cfg_q.normal[1] <= '0;
      cfg_q.normal[2] <= NORM_W'(16384);
      cfg_q.point     <= '0;
      cfg_q.keep_front <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORMAL_X:   cfg_q.normal[0]  <= cfg_data_i[NORM_W-1:0];
        CFG_NORMAL_Y:   cfg_q.normal[1]  <= cfg_data_i[NORM_W-1:0];
        CFG_NORMAL_Z:   cfg_q.normal[2]  <= cfg_data_i[NORM_W-1:0];
        CFG_POINT_X:    cfg_q.point.x    <= cfg_data_i[COORD_W-1:0];
        CFG_POINT_Y:    cfg_q.point.y    <= cfg_data_i[COORD_W-1:0];
        CFG_POINT_Z:    cfg_q.point.z    <= cfg_data_i[COORD_W-1:0];
        CFG_KEEP_FRONT: cfg_q.keep_front <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // request intake, never two triangles back to back
  logic accept;
  logic busy_q;
  logic v0_q;
  tri_t tri0_q, tri1_q, tri2_q;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      v0_q   <= 1'b0;
    end else begin
      busy_q <= accept;
      v0_q   <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) tri0_q <= to_tri(req_i);
    tri1_q <= tri0_q;
    tri2_q <= tri1_q;
  end

  // signed distances and side classification
  logic                  v2;
  logic signed [D_W-1:0] d2 [3];
  cls_t                  cls2;

  tpc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vtx_i   (tri0_q),
    .cfg_i   (cfg_q),
    .valid_o (v2),
    .d_o     (d2),
    .cls_o   (cls2)
  );

  function automatic logic [1:0] other1(logic [1:0] s);
    return (s == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] other2(logic [1:0] s);
    return (s == 2'd2) ? 2'd1 : 2'd2;
  endfunction

  // cut operands: numerator -d(odd vertex), denominator d(other) - d(odd vertex)
  logic [DEN_W-1:0] an_d [2], ad_d [2];
  logic             zero_d [2];
  logic [DEN_W-1:0] an3_q [2], ad3_q [2];
  logic             zero3_q [2];
  logic             v3_q;
  carry_t           c3_q;

  always_comb begin
    logic signed [DEN_W-1:0] d1, dk, num, den;
    logic [1:0]              ok;
    d1 = DEN_W'(d2[cls2.sel]);
    for (int k = 0; k < 2; k++) begin
      ok  = (k == 0) ? other1(cls2.sel) : other2(cls2.sel);
      dk  = DEN_W'(d2[ok]);
      num = -d1;
      den = dk - d1;
      // a vanishing denominator or opposite signs pin the cut to the odd vertex
      zero_d[k] = (den == '0) || ((num != '0) && (num[DEN_W-1] != den[DEN_W-1]));
      an_d[k]   = num[DEN_W-1] ? DEN_W'(-num) : DEN_W'(num);
      ad_d[k]   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2;
  end

  always_ff @(posedge clk_i) begin
    an3_q   <= an_d;
    ad3_q   <= ad_d;
    zero3_q <= zero_d;
    c3_q    <= '{vtx: tri2_q, cls: cls2};
  end

  // normalize the denominator below 2^32, shifting both magnitudes together and capping the numerator at it
  logic [DIV_W-1:0] an4_d [2], ad4_d [2];
  logic [DIV_W-1:0] an4_q [2], ad4_q [2];
  logic             zero4_q [2];
  logic             v4_q;
  carry_t           c4_q;

  always_comb begin
    logic [SH_W-1:0]  sh;
    logic [DEN_W-1:0] an_s, ad_s;
    for (int k = 0; k < 2; k++) begin
      sh = '0;
      for (int i = 0; i < DEN_W - DIV_W; i++) begin
        if (ad3_q[k][DIV_W+i]) sh = SH_W'(i + 1);
      end
      an_s = an3_q[k] >> sh;
      ad_s = ad3_q[k] >> sh;
      if (an_s > ad_s) an_s = ad_s;
      an4_d[k] = an_s[DIV_W-1:0];
      ad4_d[k] = ad_s[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    an4_q   <= an4_d;
    ad4_q   <= ad4_d;
    zero4_q <= zero3_q;
    c4_q    <= c3_q;
  end

  // triangle and class ride along the divider and interpolation stages
  carry_t line_q [LINE_LEN];

  always_ff @(posedge clk_i) begin
    line_q[0] <= c4_q;
    for (int i = 1; i < LINE_LEN; i++) line_q[i] <= line_q[i-1];
  end

  // two dividers, one per cut edge
  logic           tv [2];
  logic [T_W-1:0] t  [2];

  for (genvar k = 0; k < 2; k++) begin : g_div
    tpc_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v4_q),
      .an_i    (an4_q[k]),
      .ad_i    (ad4_q[k]),
      .zero_i  (zero4_q[k]),
      .valid_o (tv[k]),
      .t_o     (t[k])
    );
  end

  // edge interpolation from the odd vertex toward each of the others
  carry_t lt;
  vec_t   p1, p2 [2];
  logic   lv [2];
  vec_t   nv [2];

  assign lt    = line_q[DIV_STAGES-1];
  assign p1    = lt.vtx[lt.cls.sel];
  assign p2[0] = lt.vtx[other1(lt.cls.sel)];
  assign p2[1] = lt.vtx[other2(lt.cls.sel)];

  for (genvar k = 0; k < 2; k++) begin : g_lerp
    tpc_lerp u_lerp (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (tv[k]),
      .p1_i    (p1),
      .p2_i    (p2[k]),
      .t_i     (t[k]),
      .valid_o (lv[k]),
      .r_o     (nv[k])
    );
  end

  // assemble result triangles in input winding
  carry_t     et;
  tri_t       t0, t1;
  logic [1:0] nres;

  assign et = line_q[LINE_LEN-1];

  always_comb begin
    vec_t       vs, va, vb;
    logic [1:0] o1, o2;
    logic       fwd;
    o1  = other1(et.cls.sel);
    o2  = other2(et.cls.sel);
    vs  = et.vtx[et.cls.sel];
    va  = et.vtx[o1];
    vb  = et.vtx[o2];
    // the first other vertex follows the odd one unless the odd one is the middle
    fwd = (et.cls.sel != 2'd1);
    t0  = et.vtx;
    t1  = et.vtx;
    case (et.cls.cnt)
      2'd0: begin
        nres = 2'd0;
      end
      2'd1: begin
        nres  = 2'd1;
        t0[0] = vs;
        t0[1] = fwd ? nv[0] : nv[1];
        t0[2] = fwd ? nv[1] : nv[0];
      end
      2'd2: begin
        nres = 2'd2;
        if (fwd) begin
          t0[0] = va;    t0[1] = vb;    t0[2] = nv[0];
          t1[0] = vb;    t1[1] = nv[1]; t1[2] = nv[0];
        end else begin
          t0[0] = va;    t0[1] = nv[0]; t0[2] = vb;
          t1[0] = nv[0]; t1[1] = nv[1]; t1[2] = vb;
        end
      end
      default: begin
        nres = 2'd1;
      end
    endcase
  end

  // output register plus one pending slot for the second triangle
  logic    out_v_q, pend_v_q;
  result_t out_q, pend_q;
  logic    ev;

  assign ev = lv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= pend_v_q || (ev && (nres != 2'd0));
      pend_v_q <= ev && (nres == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= pend_v_q ? pend_q : to_result(t0, nres == 2'd1);
    pend_q <= to_result(t1, 1'b1);
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

/* hdl/tpc_assert.sv */
// tpc_assert: port-level checks of request spacing and result grouping
// depends on tpc_pkg; bound to triangle_plane_clipper
module tpc_assert (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             res_valid_o,
  input tpc_pkg::result_t res_o
);

  // a taken request blocks the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after a taken request");

  // busy lasts one cycle only
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  // a first result of a pair is followed at once by the final one
  a_pair_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o && res_o.last)
    else $error("second result of a pair missing");

endmodule

bind triangle_plane_clipper tpc_assert u_tpc_assert (.*);
